### rtl/bss_pkg.sv
// ----------------------------------------------------------------------------
// bss_pkg
// Shared widths, codes and types of the barrier schedule sequencer.
// ----------------------------------------------------------------------------
package bss_pkg;

  // Field widths.
  localparam int unsigned RANK_W    = 10;  // node rank and peer
  localparam int unsigned SIZE_W    = 11;  // group size
  localparam int unsigned DIM_W     = 4;   // tree dimension and bit position
  localparam int unsigned CNT_W     = 10;  // linear root position
  localparam int unsigned PHASE_W   = 3;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 11;  // widest register

  // Number of tree bits a cube dimension can reach, and the width of a child
  // rank that carries the highest of them.
  localparam int unsigned DIM_N   = (1 << DIM_W) - 1;
  localparam int unsigned CHILD_W = DIM_N;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned RANK_BITS_DEF = 10;

  // Sequence phases.
  localparam logic [PHASE_W-1:0] PH_IDLE         = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LIN_GATHER   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LIN_RELEASE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PARENT_SEND  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_PARENT_RECV  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_TREE_GATHER  = 3'd5;
  localparam logic [PHASE_W-1:0] PH_TREE_RELEASE = 3'd6;

  // Result actions.
  localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RECV = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DONE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FAIL = 2'd3;

  // Input operations.
  localparam logic OP_START    = 1'b0;
  localparam logic OP_COMPLETE = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NODE_RANK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUBE_DIM   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TREE_MODE  = 2'd3;

  typedef struct packed {
    logic [RANK_W-1:0] node_rank;
    logic [SIZE_W-1:0] group_size;
    logic [DIM_W-1:0]  cube_dim;
    logic              tree_mode;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [DIM_W-1:0]   bit_position;
    logic [CNT_W-1:0]   message_count;
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [RANK_W-1:0] peer;
    logic              any_source;
  } res_t;

endpackage

### rtl/bss_req_if.sv
// ----------------------------------------------------------------------------
// bss_req_if
// Event channel into the sequencer: start and completion events.
// ----------------------------------------------------------------------------
interface bss_req_if;
  logic valid;
  logic ready;
  logic op;
  logic failed;

  modport source (output valid, output op, output failed, input ready);
  modport sink (input valid, input op, input failed, output ready);
endinterface

### rtl/bss_rsp_if.sv
// ----------------------------------------------------------------------------
// bss_rsp_if
// Command channel out of the sequencer: send, receive, done and failed.
// ----------------------------------------------------------------------------
interface bss_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [bss_pkg::ACT_W-1:0]  action;
  logic [bss_pkg::RANK_W-1:0] peer;
  logic                       any_source;

  modport source (output valid, output action, output peer, output any_source, input ready);
  modport sink (input valid, input action, input peer, input any_source, output ready);
endinterface

### rtl/bss_cfg_regs.sv
// ----------------------------------------------------------------------------
// bss_cfg_regs
// Configuration registers, written by index through a plain write port.
// ----------------------------------------------------------------------------
module bss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bss_pkg::CFG_W-1:0]     cfg_data_i,
  output bss_pkg::cfg_t                 cfg_o
);

  bss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bss_pkg::REG_NODE_RANK:  cfg_d.node_rank  = cfg_data_i[bss_pkg::RANK_W-1:0];
        bss_pkg::REG_GROUP_SIZE: cfg_d.group_size = cfg_data_i[bss_pkg::SIZE_W-1:0];
        bss_pkg::REG_CUBE_DIM:   cfg_d.cube_dim   = cfg_data_i[bss_pkg::DIM_W-1:0];
        bss_pkg::REG_TREE_MODE:  cfg_d.tree_mode  = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_rank  <= '0;
      cfg_q.group_size <= bss_pkg::SIZE_W'(1);
      cfg_q.cube_dim   <= '0;
      cfg_q.tree_mode  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/bss_step.sv
// ----------------------------------------------------------------------------
// bss_step
// One step of the barrier schedule: next phase and the command to issue.
// ----------------------------------------------------------------------------
module bss_step #(
  parameter int unsigned MAX_NODES = bss_pkg::MAX_NODES_DEF,
  parameter int unsigned RANK_BITS = bss_pkg::RANK_BITS_DEF
) (
  input  bss_pkg::cfg_t   cfg_i,
  input  bss_pkg::state_t state_i,
  input  logic            op_i,
  input  logic            failed_i,
  output bss_pkg::state_t state_o,
  output bss_pkg::res_t   res_o
);

  localparam int unsigned SIZE_W  = bss_pkg::SIZE_W;
  localparam int unsigned RANK_W  = bss_pkg::RANK_W;
  localparam int unsigned DIM_W   = bss_pkg::DIM_W;
  localparam int unsigned DIM_N   = bss_pkg::DIM_N;
  localparam int unsigned CHILD_W = bss_pkg::CHILD_W;
  localparam int unsigned CNT_W   = bss_pkg::CNT_W;
  localparam int unsigned SizeCap = (MAX_NODES > ((1 << SIZE_W) - 1)) ?
                                    ((1 << SIZE_W) - 1) : MAX_NODES;
  localparam logic [SIZE_W-1:0] SIZE_CAP  = SIZE_W'(SizeCap);
  localparam logic [RANK_W-1:0] RANK_MASK = RANK_W'((33'd1 << RANK_BITS) - 33'd1);

  logic [RANK_W-1:0]      rank;
  logic [SIZE_W-1:0]      eff_size;
  logic signed [DIM_W:0]  high;        // -1 when no rank bit below cube_dim
  logic                   has_high;
  logic [RANK_W-1:0]      parent;
  logic [DIM_N-1:0]       usable;
  logic signed [DIM_W:0]  g_from;
  logic                   g_hit;
  logic [DIM_W-1:0]       g_bit;
  logic signed [DIM_W:0]  r_from;
  logic                   r_hit;
  logic [DIM_W-1:0]       r_bit;
  logic [SIZE_W-1:0]      lin_idx;
  bss_pkg::state_t        rel_state, gat_state, lg_state, lr_state;
  bss_pkg::res_t          rel_res, gat_res, lg_res, lr_res;

  assign rank = cfg_i.node_rank & RANK_MASK;

  always_comb begin
    if (cfg_i.group_size > SIZE_CAP) begin
      eff_size = SIZE_CAP;
    end else if (cfg_i.group_size == '0) begin
      eff_size = SIZE_W'(1);
    end else begin
      eff_size = cfg_i.group_size;
    end
  end

  // Highest rank bit below the cube dimension.
  always_comb begin
    high     = '1;
    has_high = 1'b0;
    for (int b = 0; b < RANK_W; b++) begin
      if (rank[b] && (DIM_W'(b) < cfg_i.cube_dim)) begin
        high     = (DIM_W + 1)'(b);
        has_high = 1'b1;
      end
    end
  end

  assign parent = (cfg_i.tree_mode && has_high) ?
                  (rank & ~(RANK_W'(1) << high[DIM_W-1:0])) : '0;

  // A child exists when its rank lies below the effective group size.
  always_comb begin
    for (int b = 0; b < DIM_N; b++) begin
      usable[b] = ((CHILD_W'(rank) | (CHILD_W'(1) << b)) < CHILD_W'(eff_size));
    end
  end

  // Gather: highest usable child bit in (high, g_from].
  assign g_from = (op_i == bss_pkg::OP_START) ?
                  ($signed({1'b0, cfg_i.cube_dim}) - 2'sd1) :
                  ($signed({1'b0, state_i.bit_position}) - 2'sd1);

  always_comb begin
    g_hit = 1'b0;
    g_bit = '0;
    for (int b = 0; b < DIM_N; b++) begin
      if (usable[b] && ($signed((DIM_W + 1)'(b)) > high) &&
          ($signed((DIM_W + 1)'(b)) <= g_from)) begin
        g_hit = 1'b1;
        g_bit = DIM_W'(b);
      end
    end
  end

  // Release: lowest usable child bit in [r_from, cube_dim).
  assign r_from = ((op_i == bss_pkg::OP_COMPLETE) &&
                   (state_i.phase == bss_pkg::PH_TREE_RELEASE)) ?
                  ($signed({1'b0, state_i.bit_position}) + 2'sd1) : (high + 2'sd1);

  always_comb begin
    r_hit = 1'b0;
    r_bit = '0;
    for (int b = DIM_N - 1; b >= 0; b--) begin
      if (usable[b] && ($signed((DIM_W + 1)'(b)) >= r_from) &&
          (DIM_W'(b) < cfg_i.cube_dim)) begin
        r_hit = 1'b1;
        r_bit = DIM_W'(b);
      end
    end
  end

  always_comb begin
    rel_state = state_i;
    rel_res   = '0;
    if (r_hit) begin
      rel_state.phase        = bss_pkg::PH_TREE_RELEASE;
      rel_state.bit_position = r_bit;
      rel_res.action         = bss_pkg::ACT_SEND;
      rel_res.peer           = rank | (RANK_W'(1) << r_bit);
    end else begin
      rel_state.phase = bss_pkg::PH_IDLE;
      rel_res.action  = bss_pkg::ACT_DONE;
    end
  end

  always_comb begin
    gat_state = state_i;
    gat_res   = '0;
    if (g_hit) begin
      gat_state.phase        = bss_pkg::PH_TREE_GATHER;
      gat_state.bit_position = g_bit;
      gat_res.action         = bss_pkg::ACT_RECV;
      gat_res.peer           = rank | (RANK_W'(1) << g_bit);
    end else if (has_high) begin
      gat_state.phase = bss_pkg::PH_PARENT_SEND;
      gat_res.action  = bss_pkg::ACT_SEND;
      gat_res.peer    = parent;
    end else begin
      gat_state = rel_state;
      gat_res   = rel_res;
    end
  end

  // Linear root: gather index, or release index on a release completion.
  assign lin_idx = (op_i == bss_pkg::OP_START) ? SIZE_W'(1) :
                   (SIZE_W'(state_i.message_count) + SIZE_W'(1));

  always_comb begin
    lr_state = state_i;
    lr_res   = '0;
    if (lin_idx < eff_size) begin
      lr_state.phase         = bss_pkg::PH_LIN_RELEASE;
      lr_state.message_count = lin_idx[CNT_W-1:0];
      lr_res.action          = bss_pkg::ACT_SEND;
      lr_res.peer            = lin_idx[RANK_W-1:0];
    end else begin
      lr_state.phase = bss_pkg::PH_IDLE;
      lr_res.action  = bss_pkg::ACT_DONE;
    end
  end

  always_comb begin
    lg_state = state_i;
    lg_res   = '0;
    if (lin_idx < eff_size) begin
      lg_state.phase         = bss_pkg::PH_LIN_GATHER;
      lg_state.message_count = lin_idx[CNT_W-1:0];
      lg_res.action          = bss_pkg::ACT_RECV;
      lg_res.any_source      = 1'b1;
    end else if (SIZE_W'(1) < eff_size) begin
      // Gather finished: release starts with rank 1.
      lg_state.phase         = bss_pkg::PH_LIN_RELEASE;
      lg_state.message_count = CNT_W'(1);
      lg_res.action          = bss_pkg::ACT_SEND;
      lg_res.peer            = RANK_W'(1);
    end else begin
      lg_state.phase = bss_pkg::PH_IDLE;
      lg_res.action  = bss_pkg::ACT_DONE;
    end
  end

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (op_i == bss_pkg::OP_START) begin
      if (cfg_i.tree_mode) begin
        state_o = gat_state;
        res_o   = gat_res;
      end else if (rank != '0) begin
        state_o.phase = bss_pkg::PH_PARENT_SEND;
        res_o.action  = bss_pkg::ACT_SEND;
      end else begin
        state_o = lg_state;
        res_o   = lg_res;
      end
    end else if ((state_i.phase == bss_pkg::PH_IDLE) || failed_i) begin
      state_o.phase = bss_pkg::PH_IDLE;
      res_o.action  = bss_pkg::ACT_FAIL;
    end else begin
      case (state_i.phase)
        bss_pkg::PH_LIN_GATHER: begin
          state_o = lg_state;
          res_o   = lg_res;
        end
        bss_pkg::PH_LIN_RELEASE: begin
          state_o = lr_state;
          res_o   = lr_res;
        end
        bss_pkg::PH_PARENT_SEND: begin
          state_o.phase = bss_pkg::PH_PARENT_RECV;
          res_o.action  = bss_pkg::ACT_RECV;
          res_o.peer    = parent;
        end
        bss_pkg::PH_PARENT_RECV: begin
          if (cfg_i.tree_mode) begin
            state_o = rel_state;
            res_o   = rel_res;
          end else begin
            state_o.phase = bss_pkg::PH_IDLE;
            res_o.action  = bss_pkg::ACT_DONE;
          end
        end
        bss_pkg::PH_TREE_GATHER: begin
          state_o = gat_state;
          res_o   = gat_res;
        end
        bss_pkg::PH_TREE_RELEASE: begin
          state_o = rel_state;
          res_o   = rel_res;
        end
        default: begin
          state_o.phase = bss_pkg::PH_IDLE;
          res_o.action  = bss_pkg::ACT_FAIL;
        end
      endcase
    end
  end

endmodule

### rtl/barrier_schedule_sequencer.sv
// ----------------------------------------------------------------------------
// barrier_schedule_sequencer
// Sequences one node's part in a linear or binomial-tree barrier.
// ----------------------------------------------------------------------------
// The req_i channel carries events: a start of a barrier, or the completion
// of the command issued last, with a flag for an error. For every event
// transaction the block returns exactly one transaction on rsp_o: the next
// zero-length send or receive with its peer rank, or barrier done, or
// barrier failed. The user carries out each send or receive and reports its
// completion as the next event.
// An event is held in an input register and the step is worked out from it
// and the sequence state into an output register, from which the result is
// offered. One event per cycle is taken while the receiver does not stall.
// The step logic is a priority encode over the tree bits, which bounds the
// clock period rather than the rate.
// When the receiver stalls, the result waits in the output register and one
// further event is held in the input register; req_i.ready then drops.
// Reset empties both registers, puts the sequence in the idle phase and
// loads the registers with rank 0, group size 1, dimension 0 and tree mode.
// Registers are written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so only while no event is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module barrier_schedule_sequencer #(
  parameter int unsigned MAX_NODES = bss_pkg::MAX_NODES_DEF,
  parameter int unsigned RANK_BITS = bss_pkg::RANK_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bss_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bss_pkg::CFG_W-1:0]     cfg_data_i,
  bss_req_if.sink                       req_i,
  bss_rsp_if.source                     rsp_o
);

  bss_pkg::cfg_t   cfg;
  bss_pkg::state_t state_q, state_d;
  bss_pkg::res_t   step_res;
  bss_pkg::res_t   res_q;

  logic in_valid_q;
  logic in_op_q;
  logic in_failed_q;
  logic out_valid_q;
  logic out_free;
  logic fire;

  bss_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The step is taken when an event is held and the output register either
  // is empty or is being emptied in this very cycle.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.valid && req_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  // Event payload; only loaded on an accepted transaction.
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_op_q     <= req_i.op;
      in_failed_q <= req_i.failed;
    end
  end

  bss_step #(
    .MAX_NODES (MAX_NODES),
    .RANK_BITS (RANK_BITS)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .op_i     (in_op_q),
    .failed_i (in_failed_q),
    .state_o  (state_d),
    .res_o    (step_res)
  );

  // Sequence state advances only with a step, so a stall never repeats one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= bss_pkg::PH_IDLE;
      state_q.bit_position  <= '0;
      state_q.message_count <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= step_res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.action     = res_q.action;
  assign rsp_o.peer       = res_q.peer;
  assign rsp_o.any_source = res_q.any_source;

  // A finished or aborted barrier leaves the sequence idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (step_res.action == bss_pkg::ACT_DONE || step_res.action == bss_pkg::ACT_FAIL)
    |=> state_q.phase == bss_pkg::PH_IDLE)
    else $error("sequence not idle after done or failed result");

  // Only a receive may accept any sender.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.any_source |-> res_q.action == bss_pkg::ACT_RECV)
    else $error("any-source flag on a result that is not a receive");

  // Done and failed results carry no peer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.action == bss_pkg::ACT_DONE || res_q.action == bss_pkg::ACT_FAIL)
    |-> res_q.peer == '0)
    else $error("peer set on a done or failed result");

  // An empty output register never holds back the event channel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("event channel stalled with an empty output register");

endmodule
